// File: src/tip_pkg.sv
package tip_pkg;

    localparam int BLOCK_LENGTH = 1784;
    localparam int SAMPLE_WIDTH = 16;
    localparam int MEM_DEPTH    = 2 * BLOCK_LENGTH;
    localparam int POS_W        = $clog2(BLOCK_LENGTH);
    localparam int MEM_ADDR_W   = $clog2(MEM_DEPTH);

    // interleaver constants
    localparam int IL_K2      = 223;
    localparam int IL_M_TERM  = 21;
    localparam int J_W        = 8;
    localparam int I_W        = 2;

    // output queue
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [MEM_ADDR_W-1:0] wr_addr;
        logic [MEM_ADDR_W-1:0] rd_addr;
        logic                  last;
        logic                  primed;
    } tip_addr_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] data;
        logic                           last;
    } tip_entry_t;

    // t = (19*i + 1) mod 4 for sub-block index i
    function automatic logic [1:0] t_of_i(input logic [I_W-1:0] i);
        logic [1:0] t;
        unique case (i)
            2'd0:    t = 2'd1;
            2'd1:    t = 2'd0;
            2'd2:    t = 2'd3;
            default: t = 2'd2;
        endcase
        return t;
    endfunction

    // prime table entry p[t]
    function automatic logic [J_W-1:0] prime_of(input logic [1:0] t);
        logic [J_W-1:0] p;
        unique case (t)
            2'd0:    p = 8'd31;
            2'd1:    p = 8'd37;
            2'd2:    p = 8'd43;
            default: p = 8'd47;
        endcase
        return p;
    endfunction

endpackage

// File: src/tip_ram.sv
module tip_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/tip_addr_gen.sv
module tip_addr_gen (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               direction,
    output tip_pkg::tip_addr_t addr
);

    logic [tip_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [tip_pkg::I_W-1:0]   sub_reg, sub_next;
    logic [tip_pkg::J_W-1:0]   pair_reg, pair_next;
    logic [tip_pkg::J_W-1:0]   res_reg, res_next;
    logic                      bank_reg, bank_next;
    logic                      primed_reg, primed_next;

    logic                      odd;
    logic [1:0]                t;
    logic [tip_pkg::J_W:0]     c_sum;
    logic [tip_pkg::J_W-1:0]   c;
    logic [tip_pkg::J_W:0]     res_sum;
    logic [tip_pkg::J_W-1:0]   res_wrap;
    logic [tip_pkg::POS_W-1:0] perm;
    logic                      last;
    logic [tip_pkg::MEM_ADDR_W-1:0] wbase, rbase, wsel, rsel;

    // permuted address pi(k)-1 = 8c + 2t + 1 - m
    always_comb
    begin
        odd   = pos_reg[0];
        t     = tip_pkg::t_of_i(sub_reg);
        c_sum = {1'b0, res_reg}
              + (odd ? (tip_pkg::J_W+1)'(tip_pkg::IL_M_TERM) : '0);
        if (c_sum >= (tip_pkg::J_W+1)'(tip_pkg::IL_K2))
        begin
            c = tip_pkg::J_W'(c_sum - (tip_pkg::J_W+1)'(tip_pkg::IL_K2));
        end
        else
        begin
            c = c_sum[tip_pkg::J_W-1:0];
        end
        perm = {c, t, ~odd};
        last = (pos_reg == tip_pkg::POS_W'(tip_pkg::BLOCK_LENGTH - 1));
    end

    // running p[t]*j mod k2
    always_comb
    begin
        res_sum = {1'b0, res_reg} + {1'b0, tip_pkg::prime_of(t)};
        if (res_sum >= (tip_pkg::J_W+1)'(tip_pkg::IL_K2))
        begin
            res_wrap = tip_pkg::J_W'(res_sum - (tip_pkg::J_W+1)'(tip_pkg::IL_K2));
        end
        else
        begin
            res_wrap = res_sum[tip_pkg::J_W-1:0];
        end
    end

    // position counters, bank swap at block end
    always_comb
    begin
        pos_next    = pos_reg;
        sub_next    = sub_reg;
        pair_next   = pair_reg;
        res_next    = res_reg;
        bank_next   = bank_reg;
        primed_next = primed_reg;
        if (advance)
        begin
            if (last)
            begin
                pos_next    = '0;
                sub_next    = '0;
                pair_next   = '0;
                res_next    = '0;
                bank_next   = ~bank_reg;
                primed_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (odd)
                begin
                    if (pair_reg == tip_pkg::J_W'(tip_pkg::IL_K2 - 1))
                    begin
                        pair_next = '0;
                        res_next  = '0;
                        sub_next  = sub_reg + 1'b1;
                    end
                    else
                    begin
                        pair_next = pair_reg + 1'b1;
                        res_next  = res_wrap;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            sub_reg    <= '0;
            pair_reg   <= '0;
            res_reg    <= '0;
            bank_reg   <= 1'b0;
            primed_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            sub_reg    <= sub_next;
            pair_reg   <= pair_next;
            res_reg    <= res_next;
            bank_reg   <= bank_next;
            primed_reg <= primed_next;
        end
    end

    // bank offsets and direction select
    always_comb
    begin
        wbase = bank_reg ? tip_pkg::MEM_ADDR_W'(tip_pkg::BLOCK_LENGTH) : '0;
        rbase = bank_reg ? '0 : tip_pkg::MEM_ADDR_W'(tip_pkg::BLOCK_LENGTH);
        wsel  = tip_pkg::MEM_ADDR_W'(direction ? perm : pos_reg);
        rsel  = tip_pkg::MEM_ADDR_W'(direction ? pos_reg : perm);
        addr.wr_addr = wbase + wsel;
        addr.rd_addr = rbase + rsel;
        addr.last    = last;
        addr.primed  = primed_reg;
    end

endmodule

// File: src/tip_out_fifo.sv
module tip_out_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  tip_pkg::tip_entry_t            push_item,
    input  logic                           pop,
    output logic                           valid,
    output tip_pkg::tip_entry_t            head,
    output logic [tip_pkg::FIFO_CNT_W-1:0] count
);

    tip_pkg::tip_entry_t               slot_reg [tip_pkg::FIFO_DEPTH];
    logic [tip_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tip_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tip_pkg::FIFO_CNT_W-1:0]    count_reg, count_next;
    logic                              do_pop;

    function automatic logic [tip_pkg::FIFO_PTR_W-1:0] bump(
        input logic [tip_pkg::FIFO_PTR_W-1:0] p
    );
        logic [tip_pkg::FIFO_PTR_W-1:0] n;
        if (p == tip_pkg::FIFO_PTR_W'(tip_pkg::FIFO_DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    // pointer and fill count update
    always_comb
    begin
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// File: src/turbo_interleaver_permuter.sv
// an item's result is read into the store's output register, then offered from the output queue
// throughput: one item per cycle if in_ready, set by the store's single write and read port pair
// the first 1784 items after reset are stored and give no result; each later item gives one
// reset clears the position, bank select, fill flag and direction (interleave); store not cleared
// a three-entry output queue lets the input side run on while the output side stalls, until full
module turbo_interleaver_permuter (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [tip_pkg::SAMPLE_WIDTH-1:0] sample,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [tip_pkg::SAMPLE_WIDTH-1:0] sample_out,
    output logic                                   last_in_block,
    input  logic                                   cfg_we,
    input  logic                                   cfg_wdata
);

    logic                                  direction_reg;
    logic                                  rd_valid_reg;
    logic                                  rd_last_reg;
    logic                                  accept;
    logic                                  rd_issue;
    tip_pkg::tip_addr_t                    addr;
    logic [tip_pkg::SAMPLE_WIDTH-1:0]      ram_rdata;
    tip_pkg::tip_entry_t                   push_item;
    tip_pkg::tip_entry_t                   head;
    logic [tip_pkg::FIFO_CNT_W-1:0]        fifo_count;

    // direction register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            direction_reg <= cfg_wdata;
        end
    end

    // room for the read in flight plus anything queued
    always_comb
    begin
        in_ready = (({1'b0, fifo_count} + {{tip_pkg::FIFO_CNT_W{1'b0}}, rd_valid_reg})
                    < (tip_pkg::FIFO_CNT_W+1)'(tip_pkg::FIFO_DEPTH));
        accept   = in_valid && in_ready;
        rd_issue = accept && addr.primed;
    end

    tip_addr_gen u_addr_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (accept),
        .direction (direction_reg),
        .addr      (addr)
    );

    tip_ram #(
        .WIDTH (tip_pkg::SAMPLE_WIDTH),
        .DEPTH (tip_pkg::MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (addr.wr_addr),
        .wdata (sample),
        .re    (rd_issue),
        .raddr (addr.rd_addr),
        .rdata (ram_rdata)
    );

    // read tracking alongside the store's output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            rd_last_reg <= addr.last;
        end
    end

    // queue results for the output side
    always_comb
    begin
        push_item.data = ram_rdata;
        push_item.last = rd_last_reg;
    end

    tip_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rd_valid_reg),
        .push_item (push_item),
        .pop       (out_ready),
        .valid     (out_valid),
        .head      (head),
        .count     (fifo_count)
    );

    assign sample_out    = head.data;
    assign last_in_block = head.last;

endmodule

// File: dv/turbo_interleaver_permuter_test.sv
`timescale 1ns / 1ps

module turbo_interleaver_permuter_test;

    typedef enum logic {
        DIR_INTERLEAVE   = 1'b0,
        DIR_DEINTERLEAVE = 1'b1
    } dir_t;

    localparam int CYCLE_LIMIT   = 800000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 16;
    localparam int MIXED_ITEMS   = 1200;

    logic                                    clk       = 1'b0;
    logic                                    rst_n     = 1'b0;
    logic                                    in_valid  = 1'b0;
    logic                                    in_ready;
    logic signed [tip_pkg::SAMPLE_WIDTH-1:0] sample    = '0;
    logic                                    out_valid;
    logic                                    out_ready = 1'b0;
    logic signed [tip_pkg::SAMPLE_WIDTH-1:0] sample_out;
    logic                                    last_in_block;
    logic                                    cfg_we    = 1'b0;
    logic                                    cfg_wdata = 1'b0;

    // shadow of the double-banked store and its counters
    logic signed [tip_pkg::SAMPLE_WIDTH-1:0] shadow_store [tip_pkg::MEM_DEPTH];
    logic                                    fill_bank    = 1'b0;
    int unsigned                             blk_pos      = 0;
    logic                                    block_primed = 1'b0;
    dir_t                                    cur_dir      = DIR_INTERLEAVE;

    tip_pkg::tip_entry_t                     permuted_due [$];
    logic signed [tip_pkg::SAMPLE_WIDTH-1:0] pending_samples [$];

    int unsigned items_queued = 0;
    int unsigned items_taken  = 0;
    int unsigned cycle_count  = 0;
    int unsigned errors       = 0;
    bit          in_took      = 1'b0;
    bit          out_took     = 1'b0;
    bit          in_calm      = 1'b0;
    bit          out_calm     = 1'b1;
    int unsigned in_hold      = 0;
    int unsigned out_hold     = 0;

    turbo_interleaver_permuter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_out    (sample_out),
        .last_in_block (last_in_block),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #2 clk = ~clk;

    // zero-based address that block position k maps to under the permutation
    function automatic int unsigned permuted_pos(input int unsigned k);
        int unsigned m, i, j, t, p, c, a;
        m = k % 2;
        i = k / (2 * tip_pkg::IL_K2);
        j = k / 2 - i * tip_pkg::IL_K2;
        t = (19 * i + 1) % 4;
        case (t)
            0:       p = 31;
            1:       p = 37;
            2:       p = 43;
            default: p = 47;
        endcase
        c = (p * j + tip_pkg::IL_M_TERM * m) % tip_pkg::IL_K2;
        a = 2 * (t + c * 4 + 1) - m - 1;
        return (a < tip_pkg::BLOCK_LENGTH) ? a : 0;
    endfunction

    // store one accepted sample and queue the sample it reads out, once primed
    task automatic permute_sample(input logic signed [tip_pkg::SAMPLE_WIDTH-1:0] s);
        int unsigned         wr_pos, rd_pos, wr_base, rd_base;
        tip_pkg::tip_entry_t e;
        wr_base = fill_bank ? tip_pkg::BLOCK_LENGTH : 0;
        rd_base = fill_bank ? 0 : tip_pkg::BLOCK_LENGTH;
        if (cur_dir == DIR_DEINTERLEAVE)
        begin
            wr_pos = permuted_pos(blk_pos);
            rd_pos = blk_pos;
        end
        else
        begin
            wr_pos = blk_pos;
            rd_pos = permuted_pos(blk_pos);
        end
        if (block_primed)
        begin
            e.data = shadow_store[rd_base + rd_pos];
            e.last = (blk_pos == tip_pkg::BLOCK_LENGTH - 1);
            permuted_due.push_back(e);
        end
        shadow_store[wr_base + wr_pos] = s;
        if (blk_pos == tip_pkg::BLOCK_LENGTH - 1)
        begin
            blk_pos      = 0;
            fill_bank    = ~fill_bank;
            block_primed = 1'b1;
        end
        else
        begin
            blk_pos++;
        end
    endtask

    // field extremes and alternating bit patterns
    function automatic logic signed [tip_pkg::SAMPLE_WIDTH-1:0] extreme_sample(
        input int unsigned n
    );
        case (n)
            0:       return {1'b0, {(tip_pkg::SAMPLE_WIDTH-1){1'b1}}};
            1:       return {1'b1, {(tip_pkg::SAMPLE_WIDTH-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            4:       return tip_pkg::SAMPLE_WIDTH'(1);
            5:       return ~tip_pkg::SAMPLE_WIDTH'(1);
            6:       return {(tip_pkg::SAMPLE_WIDTH/2){2'b01}};
            default: return {(tip_pkg::SAMPLE_WIDTH/2){2'b10}};
        endcase
    endfunction

    function automatic logic signed [tip_pkg::SAMPLE_WIDTH-1:0] noisy_sample();
        if ($urandom_range(0, 7) == 0)
            return extreme_sample($urandom_range(0, 7));
        return tip_pkg::SAMPLE_WIDTH'($urandom);
    endfunction

    task automatic offer_sample(input logic signed [tip_pkg::SAMPLE_WIDTH-1:0] s);
        pending_samples.push_back(s);
        items_queued++;
    endtask

    // hold off until every item is taken and every result is back
    task automatic wait_drained();
        while (items_taken != items_queued || permuted_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_direction(input dir_t d);
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_dir    = d;
    endtask

    // driver: sender gaps and receiver stalls, changed on the falling edge
    always @(negedge clk)
    begin : driver
        logic next_valid;
        next_valid = in_valid;
        if (rst_n)
        begin
            if (in_took)
            begin
                next_valid = 1'b0;
                in_hold    = in_calm ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 99) == 0)
                    in_calm = ~in_calm;
            end
            if (!next_valid)
            begin
                if (in_hold > 0)
                begin
                    in_hold--;
                end
                else if (pending_samples.size() > 0)
                begin
                    sample    <= pending_samples.pop_front();
                    next_valid = 1'b1;
                end
            end
            if (out_took)
            begin
                out_hold = out_calm ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 99) == 0)
                    out_calm = ~out_calm;
            end
            if (out_hold > 0)
            begin
                out_ready <= 1'b0;
                out_hold--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
        in_valid <= next_valid;
    end

    // monitor: take accepted items into the shadow, check accepted results
    always @(posedge clk)
    begin : monitor
        tip_pkg::tip_entry_t due;
        cycle_count++;
        in_took  <= rst_n && in_valid && in_ready;
        out_took <= rst_n && out_valid && out_ready;
        if (rst_n && in_valid && in_ready)
        begin
            permute_sample(sample);
            items_taken++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (permuted_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item, sample_out %0d last_in_block %0b",
                         $time, sample_out, last_in_block);
            end
            else
            begin
                due = permuted_due.pop_front();
                if (sample_out !== due.data)
                begin
                    errors++;
                    $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                             $time, due.data, sample_out);
                end
                if (last_in_block !== due.last)
                begin
                    errors++;
                    $display("%0t: last_in_block mismatch, expected %0b, actual %0b",
                             $time, due.last, last_in_block);
                end
            end
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned seg_len;
        int unsigned mixed_sent;
        mixed_sent = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first block, deinterleave throughout so that every entry of bank 0 is written
        write_direction(DIR_DEINTERLEAVE);
        for (int n = 0; n < 8; n++)
            offer_sample(extreme_sample(n));
        for (int n = 8; n < tip_pkg::BLOCK_LENGTH; n++)
            offer_sample(noisy_sample());
        wait_drained();

        // second block, interleave throughout; the first block comes out
        write_direction(DIR_INTERLEAVE);
        for (int n = 0; n < tip_pkg::BLOCK_LENGTH; n++)
            offer_sample(noisy_sample());
        wait_drained();

        // runs of random length with a fresh direction, so changes land mid-block
        while (mixed_sent < MIXED_ITEMS)
        begin
            seg_len = $urandom_range(1, 400);
            write_direction(dir_t'($urandom_range(0, 1)));
            repeat (seg_len) offer_sample(noisy_sample());
            mixed_sent += seg_len;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
